[hdl/ogg_pkg.sv]
// Shared types, constants and helpers of the occupancy grid obstacle growth unit.
// Used by every module under hdl; depends on nothing else.
package ogg_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 1024;
    localparam int GROW_RADIUS_DEF = 2;

    // Fixed field and register widths.
    localparam int DIM_W      = 11;
    localparam int COORD_W    = 10;
    localparam int OCC_W      = 8;
    localparam int S_TDATA_W  = 8;
    localparam int RES_DATA_W = 2 * COORD_W + 1;
    localparam int M_TDATA_W  = 24;

    localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

    // Output queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int FIFO_SUM_W = FIFO_CNT_W + 1;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 1;
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MAP_WIDTH  = 1'b0,
        REG_MAP_HEIGHT = 1'b1
    } cfg_reg_t;

    // Control of one item in the read-modify-write stage.
    typedef struct packed {
        logic               valid;
        logic               emit;
        logic               last;
        logic               src;
        logic               raw;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
    } item_ctl_t;

    // One result item.
    typedef struct packed {
        logic               last;
        logic               occupied;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_x;
    } res_t;

    // A zero dimension counts as one; anything above the maximum saturates.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(v) > maxv)
        begin
            r = DIM_W'(maxv);
        end
        return r;
    endfunction

endpackage

[hdl/ogg_ctrl.sv]
// Front stage: configuration registers, raster counters, cell classification
// and the flow control of the input. Depends on ogg_pkg.
module ogg_ctrl #(
    parameter int MAX_WIDTH   = ogg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = ogg_pkg::MAX_HEIGHT_DEF,
    parameter int GROW_RADIUS = ogg_pkg::GROW_RADIUS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ogg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ogg_pkg::DIM_W-1:0]           cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [ogg_pkg::OCC_W-1:0]    occ_value,
    input  logic                                flush,
    input  logic [ogg_pkg::FIFO_CNT_W-1:0]      fifo_count,
    output logic                                rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]        rd_addr,
    output ogg_pkg::item_ctl_t                  st1_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]        st1_addr,
    output logic [2*GROW_RADIUS-1:0]            st1_mask
);

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int HIST_W = 2 * GROW_RADIUS;
    localparam int DW     = ogg_pkg::DIM_W;
    localparam int CY_W   = DW + 1;
    localparam int W_EFF  = (MAX_WIDTH < (2**DW - 1)) ? MAX_WIDTH : (2**DW - 1);
    localparam int LAG_W  = $clog2(GROW_RADIUS * W_EFF + GROW_RADIUS + 1);

    logic [DW-1:0]    width_reg, width_next;
    logic [DW-1:0]    height_reg, height_next;
    logic [DW-1:0]    cx_reg, cx_next;
    logic [CY_W-1:0]  cy_reg, cy_next;
    logic [LAG_W-1:0] lag_cnt_reg, lag_cnt_next;
    logic [DW-1:0]    ox_reg, ox_next;
    logic [DW-1:0]    oy_reg, oy_next;

    ogg_pkg::item_ctl_t           st1_ctl_reg, st1_ctl_next;
    logic [XW-1:0]                st1_addr_reg;
    logic [HIST_W-1:0]            st1_mask_reg, mask;
    logic [ogg_pkg::FIFO_SUM_W-1:0] q_sum;

    logic [LAG_W-1:0] lag;
    logic             accept, emit, last, cfg_hit;
    logic             cx_wrap, ox_wrap, oy_end;
    logic             in_map, inner, raw, src;

    // Count the queued results plus the one that may still be in flight.
    assign q_sum = {1'b0, fifo_count} + ogg_pkg::FIFO_SUM_W'(st1_ctl_reg.valid & st1_ctl_reg.emit);
    assign s_tready = q_sum < ogg_pkg::FIFO_SUM_W'(ogg_pkg::FIFO_DEPTH);
    assign accept   = s_tvalid & s_tready;

    assign lag     = LAG_W'(GROW_RADIUS * int'(width_reg) + GROW_RADIUS);
    assign emit    = (lag_cnt_reg == lag);
    assign cx_wrap = (DW'(cx_reg + 1'b1) == width_reg);
    assign ox_wrap = (DW'(ox_reg + 1'b1) == width_reg);
    assign oy_end  = (DW'(oy_reg + 1'b1) == height_reg);
    assign last    = emit & ox_wrap & oy_end;

    // A source cell lies at least the radius away from every border.
    assign in_map = cy_reg < {1'b0, height_reg};
    assign inner  = (cx_reg >= DW'(GROW_RADIUS))
                  && (({1'b0, cx_reg} + (DW+1)'(GROW_RADIUS)) < {1'b0, width_reg})
                  && (cy_reg >= CY_W'(GROW_RADIUS))
                  && (({1'b0, cy_reg} + (CY_W+1)'(GROW_RADIUS)) < {2'b00, height_reg});
    assign raw    = in_map & ~flush & (occ_value != '0);
    assign src    = raw & inner;

    // History bit k of a column stands for row cy-1-k; rows before the map are masked.
    always_comb
    begin
        for (int k = 0; k < HIST_W; k++)
        begin
            mask[k] = cy_reg > CY_W'(k);
        end
    end

    always_comb
    begin
        cfg_hit = 1'b0;
        width_next  = width_reg;
        height_next = height_reg;
        case (cfg_addr)
            ogg_pkg::REG_MAP_WIDTH:
            begin
                cfg_hit    = cfg_we;
                if (cfg_we)
                begin
                    width_next = ogg_pkg::clamp_dim(cfg_data, MAX_WIDTH);
                end
            end
            ogg_pkg::REG_MAP_HEIGHT:
            begin
                cfg_hit     = cfg_we;
                if (cfg_we)
                begin
                    height_next = ogg_pkg::clamp_dim(cfg_data, MAX_HEIGHT);
                end
            end
            default:
            begin
                cfg_hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        lag_cnt_next = lag_cnt_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        if (cfg_hit || (accept && last))
        begin
            cx_next      = '0;
            cy_next      = '0;
            lag_cnt_next = '0;
            ox_next      = '0;
            oy_next      = '0;
        end
        else if (accept)
        begin
            if (cx_wrap)
            begin
                cx_next = '0;
                cy_next = cy_reg + 1'b1;
            end
            else
            begin
                cx_next = cx_reg + 1'b1;
            end
            if (!emit)
            begin
                lag_cnt_next = lag_cnt_reg + 1'b1;
            end
            else if (ox_wrap)
            begin
                ox_next = '0;
                oy_next = oy_reg + 1'b1;
            end
            else
            begin
                ox_next = ox_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        st1_ctl_next.valid  = accept;
        st1_ctl_next.emit   = emit;
        st1_ctl_next.last   = last;
        st1_ctl_next.src    = src;
        st1_ctl_next.raw    = raw;
        st1_ctl_next.cell_x = ox_reg[ogg_pkg::COORD_W-1:0];
        st1_ctl_next.cell_y = oy_reg[ogg_pkg::COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= ogg_pkg::clamp_dim(ogg_pkg::DIM_RESET, MAX_WIDTH);
            height_reg  <= ogg_pkg::clamp_dim(ogg_pkg::DIM_RESET, MAX_HEIGHT);
            cx_reg      <= '0;
            cy_reg      <= '0;
            lag_cnt_reg <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            st1_ctl_reg <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            lag_cnt_reg <= lag_cnt_next;
            ox_reg      <= ox_next;
            oy_reg      <= oy_next;
            st1_ctl_reg <= st1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st1_addr_reg <= XW'(cx_reg);
        st1_mask_reg <= mask;
    end

    assign rd_en    = accept;
    assign rd_addr  = XW'(cx_reg);
    assign st1_ctl  = st1_ctl_reg;
    assign st1_addr = st1_addr_reg;
    assign st1_mask = st1_mask_reg;

endmodule

[hdl/ogg_colmem.sv]
// Column history memory: per column the source and raw bits of the last rows,
// read, shifted and written back once per item. Depends on ogg_pkg.
module ogg_colmem #(
    parameter int MAX_WIDTH   = ogg_pkg::MAX_WIDTH_DEF,
    parameter int GROW_RADIUS = ogg_pkg::GROW_RADIUS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
    input  ogg_pkg::item_ctl_t            st1_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]  st1_addr,
    input  logic [2*GROW_RADIUS-1:0]      st1_mask,
    output logic                          col_v,
    output logic                          col_raw
);

    localparam int RAD    = GROW_RADIUS;
    localparam int HIST_W = 2 * RAD;
    localparam int ENT_W  = 3 * RAD;

    // Entry layout, newest row in the lowest bit of each part:
    // [HIST_W-1:0] source bits, [ENT_W-1:HIST_W] raw bits.
    logic [ENT_W-1:0]  mem [MAX_WIDTH];
    logic [ENT_W-1:0]  rd_data_reg, fwd_data_reg, hist, wr_data;
    logic              fwd_sel_reg, fwd_sel_next;
    logic [HIST_W-1:0] src_hist;
    logic [RAD-1:0]    raw_hist;

    // The item in the read-modify-write stage writes the entry at the same edge that this one
    // reads it, so its new value is taken over instead of the stale read.
    assign fwd_sel_next = st1_ctl.valid && (st1_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
        if (st1_ctl.valid)
        begin
            mem[st1_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_sel_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_sel_reg <= fwd_sel_next;
        end
    end

    assign hist     = fwd_sel_reg ? fwd_data_reg : rd_data_reg;
    assign src_hist = hist[HIST_W-1:0] & st1_mask;
    assign raw_hist = hist[ENT_W-1:HIST_W] & st1_mask[RAD-1:0];
    assign wr_data  = {RAD'({raw_hist, st1_ctl.raw}), HIST_W'({src_hist, st1_ctl.src})};

    assign col_v   = st1_ctl.src | (|src_hist);
    assign col_raw = raw_hist[RAD-1];

endmodule

[hdl/ogg_window.sv]
// Horizontal window: taps of the column results along the raster and the
// delayed raw bit of the reported cell. Depends on ogg_pkg.
module ogg_window #(
    parameter int GROW_RADIUS = ogg_pkg::GROW_RADIUS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ogg_pkg::item_ctl_t st1_ctl,
    input  logic               col_v,
    input  logic               col_raw,
    output logic               push,
    output ogg_pkg::res_t      res
);

    localparam int RAD    = GROW_RADIUS;
    localparam int HIST_W = 2 * RAD;

    logic [HIST_W-1:0] v_taps_reg;
    logic [RAD-1:0]    raw_taps_reg;

    // Taps advance per item, not per cycle, so bubbles do not break the window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_taps_reg   <= '0;
            raw_taps_reg <= '0;
        end
        else if (st1_ctl.valid)
        begin
            v_taps_reg   <= HIST_W'({v_taps_reg, col_v});
            raw_taps_reg <= RAD'({raw_taps_reg, col_raw});
        end
    end

    assign push         = st1_ctl.valid & st1_ctl.emit;
    assign res.cell_x   = st1_ctl.cell_x;
    assign res.cell_y   = st1_ctl.cell_y;
    assign res.last     = st1_ctl.last;
    assign res.occupied = col_v | (|v_taps_reg) | raw_taps_reg[RAD-1];

endmodule

[hdl/ogg_out_fifo.sv]
// Small result queue between the processing stage and the output stream.
// Depends on ogg_pkg.
module ogg_out_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  ogg_pkg::res_t                  push_data,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output ogg_pkg::res_t                  head,
    output logic [ogg_pkg::FIFO_CNT_W-1:0] count
);

    localparam int PW = ogg_pkg::FIFO_PTR_W;
    localparam int CW = ogg_pkg::FIFO_CNT_W;

    ogg_pkg::res_t mem_reg [ogg_pkg::FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign pop = (count_reg != '0) & m_tready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(ogg_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(ogg_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign m_tvalid = count_reg != '0;
    assign head     = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

endmodule

[hdl/occupancy_grid_obstacle_growth_unit.sv]
// Obstacle growth of a raster occupancy map, one item per cycle sustained while the
// result queue has room; the column memory does one read and one write per item and
// sets that rate. An item's result, if any, is registered in the read-modify-write
// stage, then queued; it reports the cell GROW_RADIUS*(width+1) items behind the
// input. Reset: dimensions 1024, counters zero, queue empty; the column memory is
// not cleared, since rows before the first row of a map are masked by the row count.
module occupancy_grid_obstacle_growth_unit #(
    parameter int MAX_WIDTH   = ogg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = ogg_pkg::MAX_HEIGHT_DEF,
    parameter int GROW_RADIUS = ogg_pkg::GROW_RADIUS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ogg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ogg_pkg::DIM_W-1:0]         cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ogg_pkg::S_TDATA_W-1:0]     s_tdata,  // [7:0] occ_value
    input  logic [0:0]                        s_tuser,  // [0] flush
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ogg_pkg::M_TDATA_W-1:0]     m_tdata,  // [9:0] cell_x, [19:10] cell_y, [20] occupied
    output logic                              m_tlast
);

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int HIST_W = 2 * GROW_RADIUS;

    logic                           rd_en;
    logic [XW-1:0]                  rd_addr;
    ogg_pkg::item_ctl_t             st1_ctl;
    logic [XW-1:0]                  st1_addr;
    logic [HIST_W-1:0]              st1_mask;
    logic                           col_v, col_raw, push;
    ogg_pkg::res_t                  res, head;
    logic [ogg_pkg::FIFO_CNT_W-1:0] fifo_count;

    ogg_ctrl #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .GROW_RADIUS (GROW_RADIUS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .occ_value  (s_tdata),
        .flush      (s_tuser[0]),
        .fifo_count (fifo_count),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .st1_ctl    (st1_ctl),
        .st1_addr   (st1_addr),
        .st1_mask   (st1_mask)
    );

    ogg_colmem #(
        .MAX_WIDTH   (MAX_WIDTH),
        .GROW_RADIUS (GROW_RADIUS)
    ) u_colmem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .st1_ctl  (st1_ctl),
        .st1_addr (st1_addr),
        .st1_mask (st1_mask),
        .col_v    (col_v),
        .col_raw  (col_raw)
    );

    ogg_window #(
        .GROW_RADIUS (GROW_RADIUS)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .st1_ctl (st1_ctl),
        .col_v   (col_v),
        .col_raw (col_raw),
        .push    (push),
        .res     (res)
    );

    ogg_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .head      (head),
        .count     (fifo_count)
    );

    assign m_tdata = {{(ogg_pkg::M_TDATA_W - ogg_pkg::RES_DATA_W){1'b0}},
                      head.occupied, head.cell_y, head.cell_x};
    assign m_tlast = head.last;

    // A result is never pushed into a full queue unless one leaves at the same edge.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !(m_tvalid && m_tready))
            |-> (fifo_count < ogg_pkg::FIFO_CNT_W'(ogg_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");

    // A full queue holds the input off.
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_count == ogg_pkg::FIFO_CNT_W'(ogg_pkg::FIFO_DEPTH)) |-> !s_tready)
        else $error("input accepted while result queue full");

    // Every accepted item reaches the read-modify-write stage in the next cycle.
    a_item_in_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> st1_ctl.valid)
        else $error("accepted item lost before column update");

endmodule

[test/tb_occupancy_grid_obstacle_growth_unit.sv]
`timescale 1ns / 100ps
// Testbench of occupancy_grid_obstacle_growth_unit: streams raster maps of many sizes into
// the unit and checks every cell it reports against a predictor held here.
// Depends on ogg_pkg and the unit under hdl; needs nothing else.
module tb_occupancy_grid_obstacle_growth_unit;

    localparam int RADIUS       = ogg_pkg::GROW_RADIUS_DEF;
    localparam int RING_SIZE    = 2 * RADIUS * ogg_pkg::MAX_WIDTH_DEF + 2 * RADIUS + 1;
    localparam int RANDOM_CELLS = 400;
    localparam int WIDE_CELLS   = 100;
    localparam int TALL_CELLS   = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int IDLE_PCT     = 13;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [ogg_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [ogg_pkg::DIM_W-1:0]      cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [ogg_pkg::S_TDATA_W-1:0]  s_tdata;   // [7:0] occ_value
    logic [0:0]                     s_tuser;   // [0] flush
    logic                           m_tvalid;
    logic                           m_tready;
    logic [ogg_pkg::M_TDATA_W-1:0]  m_tdata;   // [9:0] cell_x, [19:10] cell_y, [20] occupied
    logic                           m_tlast;

    // Predictor state: register copies, position in the current map, recent cell bits.
    logic [ogg_pkg::DIM_W-1:0] width_reg;
    logic [ogg_pkg::DIM_W-1:0] height_reg;
    int                        cells_taken;
    bit                        occ_ring [RING_SIZE];
    ogg_pkg::res_t             expected_cells [$];

    bit gaps_on;
    int cells_sent;
    int hold_requests;
    int mismatches;

    occupancy_grid_obstacle_growth_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eff_dim(input logic [ogg_pkg::DIM_W-1:0] v, input int limit);
        if (v == '0)
        begin
            return 1;
        end
        return (int'(v) > limit) ? limit : int'(v);
    endfunction

    // Only cells at least RADIUS away from every border may grow into their neighbors.
    function automatic bit is_grow_source(input int sx, input int sy, input int w, input int h);
        if (sx < RADIUS || sx >= w - RADIUS || sy < RADIUS || sy >= h - RADIUS)
        begin
            return 1'b0;
        end
        return occ_ring[(sx + sy * w) % RING_SIZE];
    endfunction

    function automatic void grow_predict(input logic [ogg_pkg::OCC_W-1:0] occ_value,
                                         input logic flush);
        int            w;
        int            h;
        int            total;
        int            lag;
        int            pos;
        int            x;
        int            y;
        int            dx;
        int            dy;
        bit            hit;
        ogg_pkg::res_t pred;
        w     = eff_dim(width_reg, ogg_pkg::MAX_WIDTH_DEF);
        h     = eff_dim(height_reg, ogg_pkg::MAX_HEIGHT_DEF);
        total = w * h;
        lag   = RADIUS * w + RADIUS;
        pos   = cells_taken;
        occ_ring[pos % RING_SIZE] = (pos < total) && !flush && (occ_value != '0);
        cells_taken = pos + 1;
        if (pos < lag)
        begin
            return;
        end
        pos = pos - lag;
        x   = pos % w;
        y   = pos / w;
        hit = occ_ring[pos % RING_SIZE];
        for (dy = -RADIUS; dy <= RADIUS; dy++)
        begin
            for (dx = -RADIUS; dx <= RADIUS; dx++)
            begin
                if (is_grow_source(x + dx, y + dy, w, h))
                begin
                    hit = 1'b1;
                end
            end
        end
        pred.cell_x   = ogg_pkg::COORD_W'(x);
        pred.cell_y   = ogg_pkg::COORD_W'(y);
        pred.occupied = hit;
        pred.last     = (pos == total - 1);
        expected_cells.push_back(pred);
        if (pred.last)
        begin
            cells_taken = 0;
        end
    endfunction

    task automatic send_cell(input logic [ogg_pkg::OCC_W-1:0] occ_value, input logic flush);
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= occ_value;
        s_tuser  <= flush;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        grow_predict(occ_value, flush);
        cells_sent++;
    endtask

    task automatic stop_input();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // The unit must be idle here: all results in, then a wait for items without one.
    task automatic configure_map(input logic [ogg_pkg::DIM_W-1:0] wv,
                                 input logic [ogg_pkg::DIM_W-1:0] hv);
        while (expected_cells.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= ogg_pkg::REG_MAP_WIDTH;
        cfg_data <= wv;
        @(posedge clk);
        width_reg   = wv;
        cells_taken = 0;
        cfg_addr <= ogg_pkg::REG_MAP_HEIGHT;
        cfg_data <= hv;
        @(posedge clk);
        height_reg = hv;
        cfg_we <= 1'b0;
    endtask

    // One whole map plus its flush items. With noise, some map cells carry the flush flag
    // and some padding items come unflagged with arbitrary values.
    task automatic send_map(input logic [ogg_pkg::DIM_W-1:0] wv,
                            input logic [ogg_pkg::DIM_W-1:0] hv,
                            input int density, input bit noise);
        int                        w;
        int                        total;
        int                        i;
        logic [ogg_pkg::OCC_W-1:0] v;
        logic                      f;
        configure_map(wv, hv);
        w     = eff_dim(wv, ogg_pkg::MAX_WIDTH_DEF);
        total = w * eff_dim(hv, ogg_pkg::MAX_HEIGHT_DEF);
        for (i = 0; i < total + RADIUS * w + RADIUS; i++)
        begin
            if (i < total)
            begin
                v = ($urandom_range(99) < density) ?
                    ogg_pkg::OCC_W'($urandom_range(255, 1)) : '0;
                f = noise && ($urandom_range(99) < 8);
                if (f && $urandom_range(1) == 1)
                begin
                    v = ogg_pkg::OCC_W'($urandom_range(255, 1));
                end
            end
            else
            begin
                v = ogg_pkg::OCC_W'($urandom);
                f = !(noise && $urandom_range(3) == 0);
            end
            send_cell(v, f);
        end
        stop_input();
    endtask

    // The first cells of a map only; the next register write drops the rest.
    task automatic send_partial(input logic [ogg_pkg::DIM_W-1:0] wv,
                                input logic [ogg_pkg::DIM_W-1:0] hv,
                                input int count, input int density);
        int i;
        configure_map(wv, hv);
        for (i = 0; i < count; i++)
        begin
            send_cell(($urandom_range(99) < density) ?
                      ogg_pkg::OCC_W'($urandom_range(255, 1)) : '0, 1'b0);
        end
        stop_input();
    endtask

    task automatic test_single_source();
        int                        i;
        logic [ogg_pkg::OCC_W-1:0] v;
        logic                      f;
        // 5x5 map: only the center cell can grow; corners and edges report only themselves.
        configure_map(ogg_pkg::DIM_W'(5), ogg_pkg::DIM_W'(5));
        for (i = 0; i < 37; i++)
        begin
            v = '0;
            f = 1'b0;
            case (i)
                0:  v = 8'h7F;
                7:  v = 8'hFF;
                12: v = 8'h80;
                16:
                begin
                    v = 8'hFF;
                    f = 1'b1;
                end
                24: v = 8'h01;
                27: v = 8'h55;
                30: v = 8'hAA;
                default:
                begin
                    f = (i >= 25);
                end
            endcase
            send_cell(v, f);
        end
        stop_input();
    endtask

    task automatic test_degenerate_sizes();
        send_map(ogg_pkg::DIM_W'(0), ogg_pkg::DIM_W'(0), 100, 1'b0);
        send_map(ogg_pkg::DIM_W'(1), ogg_pkg::DIM_W'(4), 60, 1'b1);
        send_map(ogg_pkg::DIM_W'(4), ogg_pkg::DIM_W'(1), 60, 1'b0);
        send_map(ogg_pkg::DIM_W'(4), ogg_pkg::DIM_W'(4), 50, 1'b1);
        send_map(ogg_pkg::DIM_W'(3), ogg_pkg::DIM_W'(9), 50, 1'b0);
    endtask

    // A partial map is dropped by a register write; the next map starts from its first cell.
    task automatic test_restart();
        int i;
        configure_map(ogg_pkg::DIM_W'(7), ogg_pkg::DIM_W'(6));
        for (i = 0; i < 10; i++)
        begin
            send_cell(ogg_pkg::OCC_W'($urandom), 1'b0);
        end
        stop_input();
        send_map(ogg_pkg::DIM_W'(6), ogg_pkg::DIM_W'(7), 40, 1'b0);
    endtask

    // A saturated width puts the first result far beyond these cells, so none may appear.
    task automatic test_widest_map();
        send_partial(ogg_pkg::DIM_W'(2047), ogg_pkg::DIM_W'(6), WIDE_CELLS, 3);
    endtask

    task automatic test_tallest_map();
        gaps_on = 1'b0;
        send_partial(ogg_pkg::DIM_W'(5), ogg_pkg::DIM_W'(2047), TALL_CELLS, 10);
        gaps_on = 1'b1;
    endtask

    task automatic test_output_stall();
        hold_requests++;
        send_map(ogg_pkg::DIM_W'(12), ogg_pkg::DIM_W'(10), 30, 1'b0);
    endtask

    task automatic test_random_maps();
        int                        start;
        logic [ogg_pkg::DIM_W-1:0] wv;
        logic [ogg_pkg::DIM_W-1:0] hv;
        start = cells_sent;
        while (cells_sent - start < RANDOM_CELLS)
        begin
            wv = ($urandom_range(3) == 0) ? ogg_pkg::DIM_W'($urandom_range(4))
                                          : ogg_pkg::DIM_W'($urandom_range(16, 5));
            hv = ($urandom_range(3) == 0) ? ogg_pkg::DIM_W'($urandom_range(4))
                                          : ogg_pkg::DIM_W'($urandom_range(16, 5));
            send_map(wv, hv, $urandom_range(100), $urandom_range(3) == 0);
        end
    endtask

    // Receiver: random idling, and a long hold-off whenever a test asks for one.
    initial
    begin : receiver
        int served;
        served   = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (served != hold_requests)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                served++;
            end
            else
            begin
                m_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        ogg_pkg::res_t want;
        ogg_pkg::res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.cell_x   = m_tdata[ogg_pkg::COORD_W-1:0];
            got.cell_y   = m_tdata[2*ogg_pkg::COORD_W-1:ogg_pkg::COORD_W];
            got.occupied = m_tdata[2*ogg_pkg::COORD_W];
            got.last     = m_tlast;
            if (expected_cells.size() == 0)
            begin
                $display("%0t: unexpected cell x=%0d y=%0d occupied=%0b last=%0b", $time,
                         got.cell_x, got.cell_y, got.occupied, got.last);
                mismatches++;
            end
            else
            begin
                want = expected_cells.pop_front();
                if (got !== want)
                begin
                    $display({"%0t: expected x=%0d y=%0d occupied=%0b last=%0b,",
                              " got x=%0d y=%0d occupied=%0b last=%0b"},
                             $time, want.cell_x, want.cell_y, want.occupied, want.last,
                             got.cell_x, got.cell_y, got.occupied, got.last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("tb_occupancy_grid_obstacle_growth_unit: done, errors");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = ogg_pkg::REG_MAP_WIDTH;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        gaps_on       = 1'b1;
        cells_sent    = 0;
        hold_requests = 0;
        mismatches    = 0;
        width_reg     = ogg_pkg::DIM_RESET;
        height_reg    = ogg_pkg::DIM_RESET;
        cells_taken   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_source();
        test_degenerate_sizes();
        test_restart();
        test_widest_map();
        test_tallest_map();
        test_output_stall();
        test_random_maps();

        while (expected_cells.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb_occupancy_grid_obstacle_growth_unit: done, clean");
        end
        else
        begin
            $display("tb_occupancy_grid_obstacle_growth_unit: done, errors");
        end
        $finish;
    end

endmodule
